// ===== sv/fir_filter_q15_saturating_assert.svh =====
// Assertion macros for the FIR filter block.
`ifndef FIR_FILTER_Q15_SATURATING_ASSERT_SVH
`define FIR_FILTER_Q15_SATURATING_ASSERT_SVH

// Antecedent in this cycle, consequent in the next.
`define FIRQ15_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fir filter assertion failed");

// Antecedent and consequent in the same cycle.
`define FIRQ15_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fir filter assertion failed");

`endif

// ===== sv/firq15_pkg.sv =====
`default_nettype none

package firq15_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int PROD_W    = 32;
  localparam int ACC_W     = 37;
  localparam int TAP_IDX_W = 4;
  localparam int TAP_CNT_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int COEF_WORDS = 4;

  localparam logic signed [ACC_W-1:0] ROUND_CONST = 37'sd16384;
  localparam logic signed [ACC_W-1:0] ACC_MAX     = 37'sd1073741823;
  localparam logic signed [ACC_W-1:0] ACC_MIN     = -37'sd1073741824;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT = 3'd0,
    REG_COEF_0    = 3'd1,
    REG_COEF_1    = 3'd2,
    REG_COEF_2    = 3'd3,
    REG_COEF_3    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_LAST,
    S_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic                 load;
    logic                 mul;
    logic                 add;
    logic                 emit;
    logic [TAP_IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [TAP_CNT_W-1:0] taps;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/firq15_ctrl.sv =====
`default_nettype none

module firq15_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  input  firq15_pkg::dp_status_t status_i,
  output firq15_pkg::dp_cmd_t    cmd_o
);
  import firq15_pkg::*;

  ctrl_state_e          state_q, state_d;
  logic [TAP_IDX_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;
  logic                 last_tap;

  assign out_free = !out_valid_q || !out_stall_i;
  assign last_tap = ({1'b0, cnt_q} == (status_i.taps - 5'd1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (status_i.taps == '0) ? S_OUT : S_MAC;
        end
      end
      S_MAC: begin
        if (last_tap) begin
          state_d = S_LAST;
        end
      end
      S_LAST: state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.idx  = cnt_q;
    cnt_d      = cnt_q;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
        cnt_d      = '0;
      end
      S_MAC: begin
        cmd_o.mul = 1'b1;
        cmd_o.add = (cnt_q != '0);
        cnt_d     = cnt_q + 4'd1;
      end
      S_LAST: cmd_o.add = 1'b1;
      S_OUT:  cmd_o.emit = out_free;
      default: cmd_o = '0;
    endcase
    out_valid_d = cmd_o.emit | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== sv/firq15_dp.sv =====
`default_nettype none

module firq15_dp #(
  parameter int TAPS = 16
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      cfg_valid_i,
  input  wire         [firq15_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire         [firq15_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire  signed [firq15_pkg::SAMPLE_W-1:0]   sample_in_i,
  input  wire                                      clear_history_i,
  input  firq15_pkg::dp_cmd_t                      cmd_i,
  output firq15_pkg::dp_status_t                   status_o,
  output logic signed [firq15_pkg::SAMPLE_W-1:0]   filtered_sample_o
);
  import firq15_pkg::*;

  localparam int IW = (TAPS > 1) ? $clog2(TAPS) : 1;

  logic [TAP_CNT_W-1:0]                  tap_count_q;
  logic [COEF_WORDS-1:0][CFG_W-1:0]      coef_q;
  logic signed [SAMPLE_W-1:0]            line_q [TAPS];
  logic signed [PROD_W-1:0]              prod_q;
  logic signed [ACC_W-1:0]               acc_q;
  logic signed [SAMPLE_W-1:0]            out_q;

  logic [CFG_W-1:0]                      coef_word;
  logic signed [SAMPLE_W-1:0]            coef_sel;
  logic signed [SAMPLE_W-1:0]            samp_sel;
  logic signed [ACC_W-1:0]               acc_sat;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= 5'd16;
      coef_q      <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_TAP_COUNT: tap_count_q <= cfg_data_i[TAP_CNT_W-1:0];
        REG_COEF_0:    coef_q[0]   <= cfg_data_i;
        REG_COEF_1:    coef_q[1]   <= cfg_data_i;
        REG_COEF_2:    coef_q[2]   <= cfg_data_i;
        REG_COEF_3:    coef_q[3]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign status_o.taps = (tap_count_q > TAP_CNT_W'(TAPS)) ? TAP_CNT_W'(TAPS) : tap_count_q;

  // tap line: entry 0 is the current sample, the rest is the history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TAPS; k++) begin
        line_q[k] <= '0;
      end
    end else if (cmd_i.load) begin
      line_q[0] <= sample_in_i;
      if (clear_history_i) begin
        for (int k = 1; k < TAPS; k++) begin
          line_q[k] <= '0;
        end
      end
    end else if (cmd_i.emit) begin
      for (int k = 1; k < TAPS; k++) begin
        line_q[k] <= line_q[k-1];
      end
    end
  end

  assign coef_word = coef_q[cmd_i.idx[3:2]];
  assign coef_sel  = $signed(coef_word[{cmd_i.idx[1:0], 4'b0000} +: SAMPLE_W]);
  assign samp_sel  = line_q[cmd_i.idx[IW-1:0]];

  always_comb begin
    if (acc_q > ACC_MAX) begin
      acc_sat = ACC_MAX;
    end else if (acc_q < ACC_MIN) begin
      acc_sat = ACC_MIN;
    end else begin
      acc_sat = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(coef_sel) * PROD_W'(samp_sel);
    end
    if (cmd_i.load) begin
      acc_q <= ROUND_CONST;
    end else if (cmd_i.add) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (cmd_i.emit) begin
      out_q <= acc_sat[30:15];
    end
  end

  assign filtered_sample_o = out_q;

endmodule

`default_nettype wire

// ===== sv/fir_filter_q15_saturating.sv =====
// FIR filter, Q15, saturating.
// Input channel: in_valid_i / in_stall_o with sample_in_i and clear_history_i.
// A word is taken when valid is high and stall is low. clear_history_i zeroes
// the delay line before the sample is used.
// Output channel: out_valid_o / out_stall_i with filtered_sample_o, held in an
// output register, so a new sample is taken while a result still waits.
// Config: cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i. Index 0 is the
// tap count, 1..4 the packed coefficient words; other indexes are ignored.
// Write config only while idle.
// One shared 16x16 multiplier walks the active taps, one tap per cycle; each
// sample goes through S_MAC, S_LAST and S_OUT (straight to S_OUT with zero taps),
// and a new sample is taken only once the result is in the output register.
// Reset: tap count 16, coefficients and history zero, output empty.
// With the output stalled the result holds and the block waits before
// writing the next one; at most one more sample is in flight.
`default_nettype none

module fir_filter_q15_saturating #(
  parameter int TAPS = 16
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire         [firq15_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire         [firq15_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire                                      in_valid_i,
  output logic                                     in_stall_o,
  input  wire  signed [firq15_pkg::SAMPLE_W-1:0]   sample_in_i,
  input  wire                                      clear_history_i,
  output logic                                     out_valid_o,
  input  wire                                      out_stall_i,
  output logic signed [firq15_pkg::SAMPLE_W-1:0]   filtered_sample_o
);
  import firq15_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  firq15_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  firq15_dp #(
    .TAPS (TAPS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .sample_in_i       (sample_in_i),
    .clear_history_i   (clear_history_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .filtered_sample_o (filtered_sample_o)
  );

endmodule

`default_nettype wire

// ===== sv/firq15_chk.sv =====
`default_nettype none
`include "fir_filter_q15_saturating_assert.svh"

module firq15_chk (
  input wire                                      clk_i,
  input wire                                      rst_ni,
  input wire                                      cfg_valid_i,
  input wire                                      cfg_ready_o,
  input wire         [firq15_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input wire         [firq15_pkg::CFG_W-1:0]      cfg_data_i,
  input wire                                      in_valid_i,
  input wire                                      in_stall_o,
  input wire  signed [firq15_pkg::SAMPLE_W-1:0]   sample_in_i,
  input wire                                      clear_history_i,
  input wire                                      out_valid_o,
  input wire                                      out_stall_i,
  input wire  signed [firq15_pkg::SAMPLE_W-1:0]   filtered_sample_o
);
  import firq15_pkg::*;

  logic in_take;
  logic unused_ok;

  assign in_take   = in_valid_i && !in_stall_o;
  assign unused_ok = ^{cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i,
                       sample_in_i, clear_history_i};

  // output word holds while stalled
  `FIRQ15_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                      out_valid_o && $stable(filtered_sample_o))
  // one sample at a time: busy right after a take
  `FIRQ15_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_take, in_stall_o)
  // a result only appears at the end of a busy period
  `FIRQ15_ASSERT_SAME(a_out_from_busy, clk_i, rst_ni, $rose(out_valid_o),
                      $past(in_stall_o))
  // no result appears the cycle right after a take
  `FIRQ15_ASSERT_NEXT(a_no_early_out, clk_i, rst_ni, in_take && !out_valid_o,
                      !out_valid_o)

endmodule

bind fir_filter_q15_saturating firq15_chk u_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .cfg_valid_i       (cfg_valid_i),
  .cfg_ready_o       (cfg_ready_o),
  .cfg_index_i       (cfg_index_i),
  .cfg_data_i        (cfg_data_i),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .sample_in_i       (sample_in_i),
  .clear_history_i   (clear_history_i),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .filtered_sample_o (filtered_sample_o)
);

`default_nettype wire
